// File: hdl/vume_pkg.sv
// ============================================================================
// vume_pkg: shared types, constants and table builders for the UV morph unit
// Holds the register indices, the default parameters, the percent-to-time
// table and the constant functions that build the easing table.
// ============================================================================
package vume_pkg;

    // Default parameter values for the top level.
    localparam int EASE_TABLE_BITS_DEF = 8;
    localparam int FRAC_BITS_DEF       = 16;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // Register indices on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIME_PERCENT = 1'b0,
        REG_UV_SCALE     = 1'b1
    } cfg_reg_t;

    localparam logic [6:0]  TIME_PERCENT_RESET = 7'd0;
    localparam logic [31:0] UV_SCALE_RESET     = 32'd65536;

    // Per-item data that rides alongside the phase divider.
    typedef struct packed {
        logic               p_one;
        logic               p_zero;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [50:0] prod_x;
        logic signed [50:0] prod_z;
    } side_t;

    // Global time in Q0.16 for each percent value, rounded half up.
    typedef logic [16:0] time_lut_t [0:127];

    function automatic time_lut_t build_time_lut();
        time_lut_t lut;
        for (int i = 0; i < 128; i++)
        begin
            lut[i] = 17'((i * 65536 + 50) / 100);
        end
        return lut;
    endfunction

    localparam time_lut_t TIME_LUT = build_time_lut();

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Ease value in Q30 for k / 2^b on the lower half, by a Taylor series.
    function automatic logic [63:0] ease_low_q30(input int unsigned k, input int unsigned b);
        logic [63:0] theta;
        logic [63:0] th2;
        logic [63:0] mag;
        longint      c;
        theta = (PI_Q30 * 64'(k)) >> b;
        th2   = (theta * theta) >> 30;
        mag   = Q30_ONE;
        c     = longint'(Q30_ONE);
        for (int n = 1; n <= 7; n++)
        begin
            mag = ((mag * th2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if ((n & 1) == 1)
                c = c - longint'(mag);
            else
                c = c + longint'(mag);
        end
        if (c < 0)
            c = 0;
        if (c > longint'(Q30_ONE))
            c = longint'(Q30_ONE);
        return (Q30_ONE - 64'(c)) >> 1;
    endfunction

    // One easing table entry in Q0.f, mirrored on the upper half.
    function automatic logic [31:0] ease_entry(input int unsigned k, input int unsigned b,
                                               input int unsigned f);
        logic [63:0] e;
        int unsigned full;
        full = 1 << b;
        if (2 * k <= full)
            e = ease_low_q30(k, b);
        else
            e = Q30_ONE - ease_low_q30(full - k, b);
        return 32'((e + (64'd1 << (29 - f))) >> (30 - f));
    endfunction

endpackage

// File: hdl/vertex_uv_morph_eased_unit.sv
// ============================================================================
// vertex_uv_morph_eased_unit: eased morph of a vertex toward its UV position
// Computes the phase of each vertex's window, eases it through an
// interpolated cosine table and blends the position toward the scaled UV.
// ============================================================================
// Usage:
//   Input items (one vertex each) enter on in_valid / in_stall and are taken
//   at an edge where in_valid is high and in_stall is low. Each item gives
//   exactly one result item on out_valid / out_stall, in order.
//   Configuration (time_percent, uv_scale) is written on cfg_valid / cfg_ready
//   with cfg_index selecting the register; cfg_ready is always high. Write it
//   only while no item is in flight.
//   Throughput is one item per cycle while the receiver does not stall. The
//   pipeline is the phase divider, which resolves one quotient bit per
//   stage, plus six stages for input capture, window set-up, table read,
//   interpolation, blend multiply and rounding.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_stall rises in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits, sets time_percent to 0 and uv_scale to 1.0.
// ============================================================================
module vertex_uv_morph_eased_unit #(
    parameter int EASE_TABLE_BITS = vume_pkg::EASE_TABLE_BITS_DEF,
    parameter int FRAC_BITS       = vume_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vume_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vume_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input items.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [31:0]                pos_x,
    input  logic signed [31:0]                pos_y,
    input  logic signed [31:0]                pos_z,
    input  logic [16:0]                       tex_u,
    input  logic [16:0]                       tex_v,
    input  logic [16:0]                       start_time,
    input  logic [16:0]                       end_time,
    // Result items.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [31:0]                out_x,
    output logic signed [31:0]                out_y,
    output logic signed [31:0]                out_z
);

    localparam int TAB_N  = (1 << EASE_TABLE_BITS) + 1;
    localparam int IDX_W  = EASE_TABLE_BITS + 1;
    localparam int E_W    = FRAC_BITS + 1;
    localparam int SIDE_W = $bits(vume_pkg::side_t);
    localparam int DIFF_W = 36;
    localparam int PW     = DIFF_W + E_W + 1;
    localparam logic [E_W-1:0] E_ONE = E_W'(1) << FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [6:0]  time_percent_reg;
    logic [31:0] uv_scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_percent_reg <= vume_pkg::TIME_PERCENT_RESET;
            uv_scale_reg     <= vume_pkg::UV_SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (vume_pkg::cfg_reg_t'(cfg_index))
                vume_pkg::REG_TIME_PERCENT: time_percent_reg <= cfg_data[6:0];
                vume_pkg::REG_UV_SCALE:     uv_scale_reg     <= cfg_data[31:0];
                default:                    ;
            endcase
        end
    end

    // Global morph time in Q0.16.
    logic [16:0] t_now;
    assign t_now = vume_pkg::TIME_LUT[time_percent_reg];

    // Easing table, folded to constants at elaboration.
    logic [E_W-1:0] ease_rom [0:TAB_N-1];
    for (genvar k = 0; k < TAB_N; k++)
    begin : g_rom
        assign ease_rom[k] = E_W'(vume_pkg::ease_entry(k, EASE_TABLE_BITS, FRAC_BITS));
    end

    // The whole pipeline moves whenever the output register is empty or its result is taken.
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // ------------------------------------------------------------------
    // Stage 0: capture the item.
    // ------------------------------------------------------------------
    logic               s0_valid_reg;
    logic signed [31:0] s0_pos_reg [0:2];
    logic [16:0]        s0_u_reg;
    logic [16:0]        s0_v_reg;
    logic [16:0]        s0_start_reg;
    logic [16:0]        s0_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_pos_reg[0] <= pos_x;
            s0_pos_reg[1] <= pos_y;
            s0_pos_reg[2] <= pos_z;
            s0_u_reg      <= tex_u;
            s0_v_reg      <= tex_v;
            s0_start_reg  <= start_time;
            s0_end_reg    <= end_time;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window set-up and target products.
    // ------------------------------------------------------------------
    logic signed [18:0] win_n;
    logic signed [18:0] win_d;
    logic [18:0]        abs_n;
    logic [18:0]        abs_d;
    logic               win_neg;
    logic               d_zero;
    logic               p_one_next;
    logic               p_zero_next;
    logic signed [50:0] cu;
    logic signed [50:0] cv;
    logic signed [50:0] scale_s;

    assign win_n   = $signed({2'b00, t_now}) - $signed({2'b00, s0_start_reg});
    assign win_d   = $signed({2'b00, s0_end_reg}) - $signed({2'b00, s0_start_reg});
    assign abs_n   = win_n[18] ? 19'(-win_n) : 19'(win_n);
    assign abs_d   = win_d[18] ? 19'(-win_d) : 19'(win_d);
    assign win_neg = win_n[18] ^ win_d[18];
    assign d_zero  = (win_d == '0);

    always_comb
    begin
        if (d_zero)
        begin
            p_one_next  = !win_n[18];
            p_zero_next = win_n[18];
        end
        else
        begin
            p_zero_next = (win_n == '0) || win_neg;
            p_one_next  = !p_zero_next && (abs_n >= abs_d);
        end
    end

    assign cu      = 51'($signed({1'b0, s0_u_reg})) - 51'sd32768;
    assign cv      = 51'($signed({1'b0, s0_v_reg})) - 51'sd32768;
    assign scale_s = $signed({19'd0, uv_scale_reg});

    logic                  s1_valid_reg;
    logic [16:0]           s1_num_reg;
    logic [16:0]           s1_den_reg;
    vume_pkg::side_t       s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_num_reg         <= abs_n[16:0];
            s1_den_reg         <= abs_d[16:0];
            s1_side_reg.p_one  <= p_one_next;
            s1_side_reg.p_zero <= p_zero_next;
            s1_side_reg.pos_x  <= s0_pos_reg[0];
            s1_side_reg.pos_y  <= s0_pos_reg[1];
            s1_side_reg.pos_z  <= s0_pos_reg[2];
            s1_side_reg.prod_x <= cu * scale_s;
            s1_side_reg.prod_z <= cv * scale_s;
        end
    end

    // ------------------------------------------------------------------
    // Phase divider.
    // ------------------------------------------------------------------
    logic                 div_valid;
    logic [FRAC_BITS-1:0] div_quot;
    logic [SIDE_W-1:0]    div_side_bits;
    vume_pkg::side_t      div_side;

    vume_divider #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .in_num    (s1_num_reg),
        .in_den    (s1_den_reg),
        .in_side   (s1_side_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side_bits)
    );

    assign div_side = vume_pkg::side_t'(div_side_bits);

    // ------------------------------------------------------------------
    // Stage E1: phase, table read and targets.
    // ------------------------------------------------------------------
    logic [E_W-1:0]             phase;
    logic [FRAC_BITS+EASE_TABLE_BITS:0] ph_pos;
    logic [IDX_W-1:0]           idx_lo;
    logic [IDX_W-1:0]           idx_hi;
    logic signed [50:0]         prod_y;
    logic signed [50:0]         rnd_x;
    logic signed [50:0]         rnd_y;
    logic signed [50:0]         rnd_z;

    assign phase  = div_side.p_one  ? E_ONE :
                    div_side.p_zero ? '0    : {1'b0, div_quot};
    assign ph_pos = {phase, {EASE_TABLE_BITS{1'b0}}};
    assign idx_lo = ph_pos[FRAC_BITS+EASE_TABLE_BITS:FRAC_BITS];
    assign idx_hi = (idx_lo == IDX_W'(TAB_N - 1)) ? idx_lo : IDX_W'(idx_lo + 1'b1);

    // Target y is fixed by the scale alone: the coordinate is zero.
    assign prod_y = -$signed({4'd0, uv_scale_reg, 15'd0});
    assign rnd_x  = div_side.prod_x + 51'sd32768;
    assign rnd_y  = prod_y + 51'sd32768;
    assign rnd_z  = div_side.prod_z + 51'sd32768;

    logic                 e1_valid_reg;
    logic [E_W-1:0]       e1_ta_reg;
    logic [E_W-1:0]       e1_tb_reg;
    logic [FRAC_BITS-1:0] e1_fr_reg;
    logic signed [31:0]   e1_pos_reg [0:2];
    logic signed [34:0]   e1_tgt_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e1_valid_reg <= 1'b0;
        else if (en)
            e1_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_ta_reg     <= ease_rom[idx_lo];
            e1_tb_reg     <= ease_rom[idx_hi];
            e1_fr_reg     <= ph_pos[FRAC_BITS-1:0];
            e1_pos_reg[0] <= div_side.pos_x;
            e1_pos_reg[1] <= div_side.pos_y;
            e1_pos_reg[2] <= div_side.pos_z;
            e1_tgt_reg[0] <= rnd_x[50:16];
            e1_tgt_reg[1] <= rnd_y[50:16];
            e1_tgt_reg[2] <= rnd_z[50:16];
        end
    end

    // ------------------------------------------------------------------
    // Stage E2: linear interpolation between table entries.
    // ------------------------------------------------------------------
    logic [2*E_W:0] interp;

    assign interp = (2*E_W+1)'(e1_ta_reg * (E_ONE - {1'b0, e1_fr_reg}))
                  + (2*E_W+1)'(e1_tb_reg * {1'b0, e1_fr_reg});

    logic               e2_valid_reg;
    logic [E_W-1:0]     e2_ease_reg;
    logic signed [31:0] e2_pos_reg [0:2];
    logic signed [34:0] e2_tgt_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e2_valid_reg <= 1'b0;
        else if (en)
            e2_valid_reg <= e1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e2_ease_reg <= interp[2*FRAC_BITS:FRAC_BITS];
            e2_pos_reg  <= e1_pos_reg;
            e2_tgt_reg  <= e1_tgt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages E3 and output: blend multiply, rounding and saturation.
    // ------------------------------------------------------------------
    logic               e3_valid_reg;
    logic signed [31:0] e3_pos_reg [0:2];
    logic signed [PW-1:0] e3_prod_reg [0:2];

    logic signed [31:0] out_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e3_valid_reg  <= e2_valid_reg;
            out_valid_reg <= e3_valid_reg;
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        logic signed [DIFF_W-1:0] diff;
        logic signed [PW-1:0]     rounded;
        logic signed [PW-1:0]     sum;
        logic signed [31:0]       sat_next;

        assign diff = DIFF_W'(e2_tgt_reg[c]) - DIFF_W'(e2_pos_reg[c]);

        // Round half up, then clamp to the signed 32-bit range.
        assign rounded = (e3_prod_reg[c] + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        assign sum     = rounded + PW'(e3_pos_reg[c]);

        always_comb
        begin
            if (sum > PW'(64'sd2147483647))
                sat_next = 32'sh7FFFFFFF;
            else if (sum < -PW'(64'sd2147483648))
                sat_next = 32'sh80000000;
            else
                sat_next = sum[31:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                e3_pos_reg[c]  <= e2_pos_reg[c];
                e3_prod_reg[c] <= PW'(diff) * PW'($signed({1'b0, e2_ease_reg}));
                out_reg[c]     <= sat_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_reg[0];
    assign out_y     = out_reg[1];
    assign out_z     = out_reg[2];

endmodule

// File: hdl/vume_divider.sv
// ============================================================================
// vume_divider: pipelined restoring divider for the morph phase
// One quotient bit per stage; side data and valid bits travel with each item.
// ============================================================================
module vume_divider #(
    parameter int FRAC_BITS = vume_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = $bits(vume_pkg::side_t)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [16:0]          in_num,
    input  logic [16:0]          in_den,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [FRAC_BITS-1:0] out_quot,
    output logic [SIDE_W-1:0]    out_side
);

    logic                 valid_reg [0:FRAC_BITS-1];
    logic [16:0]          rem_reg   [0:FRAC_BITS-1];
    logic [16:0]          den_reg   [0:FRAC_BITS-1];
    logic [FRAC_BITS-1:0] quot_reg  [0:FRAC_BITS-1];
    logic [SIDE_W-1:0]    side_reg  [0:FRAC_BITS-1];

    for (genvar i = 0; i < FRAC_BITS; i++)
    begin : g_step
        logic                 v_in;
        logic [16:0]          rem_in;
        logic [16:0]          den_in;
        logic [FRAC_BITS-1:0] quot_in;
        logic [SIDE_W-1:0]    side_in;
        logic [17:0]          shifted;
        logic                 fits;
        logic [16:0]          rem_next;

        // The first stage takes the item from the ports, the others from the stage before.
        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_num;
            assign den_in  = in_den;
            assign quot_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign quot_in = quot_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        // One trial subtraction yields one quotient bit.
        assign shifted  = {rem_in, 1'b0};
        assign fits     = (shifted >= {1'b0, den_in});
        assign rem_next = fits ? 17'(shifted - {1'b0, den_in}) : shifted[16:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_in;
                quot_reg[i] <= {quot_in[FRAC_BITS-2:0], fits};
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[FRAC_BITS-1];
    assign out_quot  = quot_reg[FRAC_BITS-1];
    assign out_side  = side_reg[FRAC_BITS-1];

endmodule
